[hw/rtl/pca_cwt_pkg.sv]
package pca_cwt_pkg;

  // Fixed field widths
  localparam int unsigned MODES_W   = 12;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned SHIFTS_W  = 20;
  localparam int unsigned CFG_W     = 20;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned SHIFT_W   = 5;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned OVF_W     = 8;
  localparam int unsigned STAMP_W   = OVF_W + COUNT_W;
  localparam int unsigned DIFF_W    = 32;
  localparam int unsigned CH_W      = 2;

  localparam logic [COUNT_W-1:0] WIDTH_SAT = 16'hFFFF;

  typedef enum logic [0:0] {
    OP_OVERFLOW = 1'b0,
    OP_EVENT    = 1'b1
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_UNUSED  = 3'd0,
    MODE_CAPTURE = 3'd1,
    MODE_PWM     = 3'd2,
    MODE_TIMER   = 3'd3,
    MODE_PULSE   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CAPTURE = 2'd0,
    KIND_PWM     = 2'd1,
    KIND_TIMER   = 2'd2,
    KIND_PULSE   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODES    = 3'd0,
    REG_ONE_SHOT = 3'd1,
    REG_SHIFTS   = 3'd2,
    REG_PERIOD_0 = 3'd3,
    REG_PERIOD_1 = 3'd4,
    REG_PERIOD_2 = 3'd5,
    REG_PERIOD_3 = 3'd6
  } reg_idx_t;

  typedef struct packed {
    op_t                op;
    logic [CH_W-1:0]    channel;
    logic [COUNT_W-1:0] captured_count;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]    out_channel;
    kind_t              event_kind;
    logic [COUNT_W-1:0] width;
    logic [COUNT_W-1:0] next_compare;
    logic               notify;
  } out_item_t;

endpackage

[hw/rtl/pca_capture_width_and_timer_engine.sv]
// Capture / compare event engine for a programmable counter array.
//
// Input channel (in_valid / in_ready / in_item): one event per item. An
// overflow item bumps every channel's 8-bit overflow count and gives no
// result. A channel event gives at most one result item, chosen by the
// channel's mode: capture width, pwm notice, timer or pulse compare reload.
// Output channel (out_valid / out_ready / out_item) carries those results.
//
// Results are registered: output register, or skid register on a stall.
// Throughput: one item per cycle while in_ready is high; state is read and
// updated in the cycle of acceptance, so each event sees the effect of the
// one before it. Path: one 25-bit subtract, 32-bit right shifter, 16-bit add.
//
// Stall: results sit in an output register backed by a one-entry skid
// register, so input is still taken while a result waits. in_ready drops
// only once the skid register is also holding an item.
//
// Reset (rst, synchronous) clears registers, counts, timestamps, compare
// values, disable bits; both output slots empty. No clearing pass. The user
// writes configuration (cfg_write/cfg_index/cfg_data) while idle; unchecked.
module pca_capture_width_and_timer_engine #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pca_cwt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pca_cwt_pkg::CFG_W-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pca_cwt_pkg::in_item_t               in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pca_cwt_pkg::out_item_t              out_item
);
  import pca_cwt_pkg::*;

  // Configuration registers
  logic [MODES_W-1:0]  channel_modes;
  logic [MASK_W-1:0]   one_shot_mask;
  logic [SHIFTS_W-1:0] capture_shifts;
  logic [COUNT_W-1:0]  period [NUM_CHANNELS];

  // Per-channel state
  logic [OVF_W-1:0]        ovf_count     [NUM_CHANNELS];
  logic [STAMP_W-1:0]      last_stamp    [NUM_CHANNELS];
  logic [COUNT_W-1:0]      compare_value [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] channel_disabled;

  // Output register plus skid slot
  logic      skid_valid;
  out_item_t skid_item;

  // Selected channel state
  logic               ch_hit;
  mode_t              sel_mode;
  logic [OVF_W-1:0]   sel_ovf;
  logic [STAMP_W-1:0] sel_last;
  logic [COUNT_W-1:0] sel_cmp;
  logic [COUNT_W-1:0] sel_period;
  logic [SHIFT_W-1:0] sel_shift;
  logic               sel_one_shot;
  logic               sel_dis;

  logic [STAMP_W-1:0] stamp;
  logic [STAMP_W:0]   diff_raw;
  logic [DIFF_W-1:0]  diff_ext;
  logic [DIFF_W-1:0]  diff_shifted;
  logic [COUNT_W-1:0] width_val;
  logic [COUNT_W-1:0] cmp_sum;

  logic      accept;
  logic      has_result;
  logic      push;
  logic      pop;
  out_item_t res;

  assign accept   = in_valid && in_ready;
  assign in_ready = !skid_valid;
  assign pop      = out_valid && out_ready;
  assign push     = accept && has_result;

  // Pick the event channel's state; lanes beyond NUM_CHANNELS never hit.
  always_comb begin
    ch_hit       = 1'b0;
    sel_mode     = MODE_UNUSED;
    sel_ovf      = '0;
    sel_last     = '0;
    sel_cmp      = '0;
    sel_period   = '0;
    sel_shift    = '0;
    sel_one_shot = 1'b0;
    sel_dis      = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (in_item.channel == CH_W'(c)) begin
        ch_hit       = 1'b1;
        sel_mode     = mode_t'(channel_modes[MODE_W*c +: MODE_W]);
        sel_ovf      = ovf_count[c];
        sel_last     = last_stamp[c];
        sel_cmp      = compare_value[c];
        sel_period   = period[c];
        sel_shift    = capture_shifts[SHIFT_W*c +: SHIFT_W];
        sel_one_shot = one_shot_mask[c];
        sel_dis      = channel_disabled[c];
      end
    end
  end

  // Width: difference is taken modulo 2^32, so a borrow fills the top byte.
  always_comb begin
    stamp        = {sel_ovf, in_item.captured_count};
    diff_raw     = {1'b0, stamp} - {1'b0, sel_last};
    diff_ext     = {{(DIFF_W-STAMP_W){diff_raw[STAMP_W]}}, diff_raw[STAMP_W-1:0]};
    diff_shifted = diff_ext >> sel_shift;
    width_val    = (|diff_shifted[STAMP_W-1:COUNT_W]) ? WIDTH_SAT
                                                      : diff_shifted[COUNT_W-1:0];
    cmp_sum      = sel_cmp + sel_period;
  end

  always_comb begin
    res             = '0;
    res.out_channel = in_item.channel;
    has_result      = 1'b0;
    unique case (sel_mode)
      MODE_CAPTURE: begin
        has_result     = 1'b1;
        res.event_kind = KIND_CAPTURE;
        res.width      = width_val;
        res.notify     = 1'b1;
      end
      MODE_PWM: begin
        has_result     = 1'b1;
        res.event_kind = KIND_PWM;
        res.notify     = 1'b1;
      end
      MODE_TIMER: begin
        has_result       = 1'b1;
        res.event_kind   = KIND_TIMER;
        res.next_compare = cmp_sum;
        res.notify       = 1'b1;
      end
      MODE_PULSE: begin
        has_result       = 1'b1;
        res.event_kind   = KIND_PULSE;
        res.next_compare = cmp_sum;
      end
      default: has_result = 1'b0;
    endcase
    if (in_item.op == OP_OVERFLOW || !ch_hit || sel_dis) begin
      has_result = 1'b0;
    end
  end

  // Configuration and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_modes    <= '0;
      one_shot_mask    <= '0;
      capture_shifts   <= '0;
      channel_disabled <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        period[c]        <= '0;
        ovf_count[c]     <= '0;
        last_stamp[c]    <= '0;
        compare_value[c] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == REG_MODES) begin
        channel_modes    <= cfg_data[MODES_W-1:0];
        channel_disabled <= '0;
        // restart capture on channels whose mode changes
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (cfg_data[MODE_W*c +: MODE_W] != channel_modes[MODE_W*c +: MODE_W]) begin
            ovf_count[c]  <= '0;
            last_stamp[c] <= '0;
          end
        end
      end else if (cfg_index == REG_ONE_SHOT) begin
        one_shot_mask <= cfg_data[MASK_W-1:0];
      end else if (cfg_index == REG_SHIFTS) begin
        capture_shifts <= cfg_data[SHIFTS_W-1:0];
      end else begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (cfg_index == CFG_IDX_W'(int'(REG_PERIOD_0) + c)) begin
            period[c]        <= cfg_data[COUNT_W-1:0];
            compare_value[c] <= cfg_data[COUNT_W-1:0];
          end
        end
      end
    end else if (accept) begin
      if (in_item.op == OP_OVERFLOW) begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          ovf_count[c] <= ovf_count[c] + 1'b1;
        end
      end else if (has_result) begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (in_item.channel == CH_W'(c)) begin
            if (sel_mode == MODE_CAPTURE) begin
              last_stamp[c] <= stamp;
              if (sel_one_shot) begin
                channel_disabled[c] <= 1'b1;
              end
            end else if (sel_mode == MODE_TIMER || sel_mode == MODE_PULSE) begin
              compare_value[c] <= cmp_sum;
            end
          end
        end
      end
    end
  end

  // Output register and skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_item <= skid_item;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_item <= res;
      end else begin
        skid_item <= res;
      end
    end
  end

  // Checks
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while output slot empty");

  a_stall_fills_skid : assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && !out_ready) |=> skid_valid)
    else $error("result lost while output stalled");

  a_overflow_silent : assert property (@(posedge clk) disable iff (rst)
    (accept && in_item.op == OP_OVERFLOW && !out_valid) |=> !out_valid)
    else $error("overflow item produced a result");

  a_one_shot_disables : assert property (@(posedge clk) disable iff (rst)
    (push && sel_mode == MODE_CAPTURE && sel_one_shot) |=> (channel_disabled != '0))
    else $error("one-shot capture left channel enabled");

endmodule
